// ===== hw/rtl/fbts_pkg.sv =====
// Shared types, codes, field layout and the blend function for the face box track smoother.
// No dependencies; imported by fbts_track and face_box_track_smoother.
`default_nettype none

package fbts_pkg;

    localparam int LANDMARK_COUNT = 5;
    localparam int COORD_BITS     = 16;
    localparam int NCOORD         = 14;
    localparam int FIELD_BITS     = 16;

    typedef logic [FIELD_BITS-1:0]  t_coord;
    typedef t_coord [NCOORD-1:0]    t_coords;

    localparam t_coord COORD_MASK = t_coord'((32'd1 << COORD_BITS) - 32'd1);

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // action codes
    localparam logic [1:0] ACT_QUERY = 2'd0;
    localparam logic [1:0] ACT_FACE  = 2'd1;
    localparam logic [1:0] ACT_EMPTY = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_DETECT_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_SMOOTH_WEIGHT   = 2'd1;
    localparam logic [1:0] CFG_MISS_GRACE      = 2'd2;

    // input tdata layout
    localparam int IN_FW_LSB    = 0;
    localparam int IN_FH_LSB    = 14;
    localparam int IN_COORD_LSB = 28;
    localparam int IN_DATA_BITS = 256;

    // output tdata layout
    localparam int OUT_DET_BIT   = 0;
    localparam int OUT_VALID_BIT = 1;
    localparam int OUT_MISS_LSB  = 2;
    localparam int OUT_COORD_LSB = 10;
    localparam int OUT_DATA_BITS = 240;

    typedef struct packed {
        logic [1:0]  action;
        logic [13:0] frame_w;
        logic [13:0] frame_h;
        t_coords     coords;
        logic [31:0] area;
        logic        last;
    } t_item;

    typedef struct packed {
        logic        detect_now;
        logic        track_valid;
        logic [7:0]  miss_count;
        t_coords     coords;
    } t_result;

    // EMA with weight in Q1.16, round to nearest: fresh + w*(held - fresh)
    function automatic t_coord blend(t_coord held, t_coord fresh, logic [16:0] w);
        logic signed [17:0] diff;
        logic signed [35:0] prod;
        logic [35:0]        sum;
        diff  = $signed({2'b00, held}) - $signed({2'b00, fresh});
        prod  = diff * $signed({1'b0, w});
        sum   = $unsigned(prod) + {4'b0000, fresh, 16'h0000} + 36'd32768;
        blend = sum[31:16] & COORD_MASK;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/face_box_track_smoother.sv =====
// Top level of the face box track smoother: stream ports, input and result registers.
// Depends on fbts_pkg and fbts_track.
//
//  channel  | dir | handshake                         | payload
//  ---------+-----+-----------------------------------+------------------------------------
//  s_axis   | in  | i_s_axis_tvalid / o_s_axis_tready | tdata, tuser = action, tlast
//  m_axis   | out | o_m_axis_tvalid / i_m_axis_tready | tdata = result item
//  cfg      | in  | i_cfg_we                          | i_cfg_index, i_cfg_data
//
// One item per cycle while the output register is not stalled: an item waits in the input
// register, the update and EMA blend (14 parallel multipliers) run combinationally as it
// leaves, and the result is registered in the output register, which offers it.
// Stalls: the input register drains whenever the output register is empty or taken.
// Reset is synchronous, active low; it clears the track and restores register defaults.
`default_nettype none

module face_box_track_smoother
    import fbts_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // frame_width[13:0], frame_height[27:14], face_x, face_y, face_w, face_h,
    // marks_front, marks_middle, marks_back[251:220], zero pad
    input  wire logic [IN_DATA_BITS-1:0]  i_s_axis_tdata,
    // action[1:0]
    input  wire logic [1:0]               i_s_axis_tuser,
    // last_face
    input  wire logic                     i_s_axis_tlast,
    output logic                          o_m_axis_tvalid,
    input  wire logic                     i_m_axis_tready,
    // detect_now[0], track_valid[1], miss_count[9:2], track_x, track_y, track_w,
    // track_h, track_marks_front, track_marks_middle, track_marks_back[233:202], zero pad
    output logic [OUT_DATA_BITS-1:0]      o_m_axis_tdata,
    input  wire logic                     i_cfg_we,
    input  wire logic [1:0]               i_cfg_index,
    input  wire logic [16:0]              i_cfg_data
);

    t_item   s_item;
    t_item   r_item;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    logic    out_free;
    logic    fire;
    logic    emit;
    t_result result;

    always_comb begin
        s_item.action  = i_s_axis_tuser;
        s_item.frame_w = i_s_axis_tdata[IN_FW_LSB +: 14];
        s_item.frame_h = i_s_axis_tdata[IN_FH_LSB +: 14];
        s_item.last    = i_s_axis_tlast;
        for (int i = 0; i < NCOORD; i++) begin
            if (i >= 4 + 2 * LANDMARK_COUNT) begin
                s_item.coords[i] = '0;
            end else begin
                s_item.coords[i] = i_s_axis_tdata[IN_COORD_LSB + FIELD_BITS * i +: FIELD_BITS]
                                   & COORD_MASK;
            end
        end
        s_item.area = 32'(s_item.coords[2]) * 32'(s_item.coords[3]);
    end

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item <= s_item;
        end
    end

    fbts_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_item      (r_item),
        .o_emit      (emit),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;

    always_comb begin
        o_m_axis_tdata                = '0;
        o_m_axis_tdata[OUT_DET_BIT]   = r_out.detect_now;
        o_m_axis_tdata[OUT_VALID_BIT] = r_out.track_valid;
        o_m_axis_tdata[OUT_MISS_LSB +: 8] = r_out.miss_count;
        for (int i = 0; i < NCOORD; i++) begin
            o_m_axis_tdata[OUT_COORD_LSB + FIELD_BITS * i +: FIELD_BITS] = r_out.coords[i];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fbts_track.sv =====
// Track state, configuration registers and per-item update logic.
// Depends on fbts_pkg.
`default_nettype none

module fbts_track
    import fbts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data,
    input  wire logic        i_fire,
    input  wire t_item       i_item,
    output logic             o_emit,
    output t_result          o_result
);

    logic [7:0]  r_interval;
    logic [16:0] r_weight;
    logic [7:0]  r_grace;

    logic [13:0] r_seen_w, n_seen_w;
    logic [13:0] r_seen_h, n_seen_h;
    logic        r_holding, n_holding;
    t_coords     r_held, n_held;
    logic [7:0]  r_miss, n_miss;
    logic [7:0]  r_skip, n_skip;
    t_coords     r_best, n_best;
    logic [31:0] r_best_area, n_best_area;
    logic        r_best_seen, n_best_seen;

    logic        det;
    logic        drop;
    logic        win;
    logic [16:0] w_sat;
    t_coords     cur_best;
    logic [7:0]  miss_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= 8'd1;
            r_weight   <= 17'd32768;
            r_grace    <= 8'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DETECT_INTERVAL: r_interval <= i_cfg_data[7:0];
                CFG_SMOOTH_WEIGHT:   r_weight   <= i_cfg_data;
                CFG_MISS_GRACE:      r_grace    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_seen_w    = r_seen_w;
        n_seen_h    = r_seen_h;
        n_holding   = r_holding;
        n_held      = r_held;
        n_miss      = r_miss;
        n_skip      = r_skip;
        n_best      = r_best;
        n_best_area = r_best_area;
        n_best_seen = r_best_seen;
        det         = 1'b0;
        drop        = 1'b0;
        o_emit      = 1'b0;

        w_sat    = (r_weight > ONE_Q16) ? ONE_Q16 : r_weight;
        win      = !r_best_seen || (i_item.area > r_best_area);
        cur_best = win ? i_item.coords : r_best;
        miss_inc = (r_miss == 8'hFF) ? r_miss : r_miss + 8'd1;

        if (i_fire) begin
            case (i_item.action)
                ACT_QUERY: begin
                    n_best_seen = 1'b0;
                    o_emit      = 1'b1;
                    det         = 1'b1;
                    if (i_item.frame_w != r_seen_w || i_item.frame_h != r_seen_h) begin
                        n_seen_w = i_item.frame_w;
                        n_seen_h = i_item.frame_h;
                        drop     = 1'b1;
                    end else if (r_holding && r_miss == 8'd0 && r_interval > 8'd1) begin
                        if ({1'b0, r_skip} + 9'd1 < {1'b0, r_interval}) begin
                            n_skip = r_skip + 8'd1;
                            det    = 1'b0;
                        end
                    end
                end
                ACT_FACE: begin
                    n_best_seen = 1'b1;
                    if (win) begin
                        n_best      = i_item.coords;
                        n_best_area = i_item.area;
                    end
                    if (i_item.last) begin
                        for (int i = 0; i < NCOORD; i++) begin
                            n_held[i] = r_holding ? blend(r_held[i], cur_best[i], w_sat)
                                                  : cur_best[i];
                        end
                        n_holding   = 1'b1;
                        n_miss      = 8'd0;
                        n_skip      = 8'd0;
                        n_best_seen = 1'b0;
                        o_emit      = 1'b1;
                    end
                end
                ACT_EMPTY: begin
                    n_best_seen = 1'b0;
                    o_emit      = 1'b1;
                    if (r_holding) begin
                        n_miss = miss_inc;
                        if (miss_inc > r_grace) begin
                            drop = 1'b1;
                        end
                    end
                end
                ACT_CLEAR: begin
                    drop        = 1'b1;
                    n_seen_w    = 14'd0;
                    n_seen_h    = 14'd0;
                    n_best_seen = 1'b0;
                end
                default: ;
            endcase
        end

        if (drop) begin
            n_holding = 1'b0;
            n_held    = '0;
            n_miss    = 8'd0;
            n_skip    = 8'd0;
        end

        o_result.detect_now  = det;
        o_result.track_valid = n_holding;
        o_result.miss_count  = n_miss;
        o_result.coords      = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_w    <= 14'd0;
            r_seen_h    <= 14'd0;
            r_holding   <= 1'b0;
            r_held      <= '0;
            r_miss      <= 8'd0;
            r_skip      <= 8'd0;
            r_best_seen <= 1'b0;
        end else begin
            r_seen_w    <= n_seen_w;
            r_seen_h    <= n_seen_h;
            r_holding   <= n_holding;
            r_held      <= n_held;
            r_miss      <= n_miss;
            r_skip      <= n_skip;
            r_best_seen <= n_best_seen;
        end
    end

    // candidate payload, qualified by r_best_seen
    always_ff @(posedge i_clk) begin
        r_best      <= n_best;
        r_best_area <= n_best_area;
    end

`ifndef NO_ASSERTIONS
    a_clear_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.action == ACT_CLEAR |=> !r_holding && r_seen_w == 14'd0)
        else $error("track held after clear");

    a_idle_track_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_holding |-> r_miss == 8'd0 && r_skip == 8'd0 && r_held == '0)
        else $error("stale track state without a held box");

    a_last_face_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.action == ACT_FACE && i_item.last
            |-> o_emit && o_result.track_valid && o_result.miss_count == 8'd0)
        else $error("closing candidate did not produce a valid track");
`endif

endmodule

`default_nettype wire
